// ----- design/sctc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sctc_pkg
// Shared constants and the month lookup for the seconds to calendar pipeline.
// ----------------------------------------------------------------------------
package sctc_pkg;

  // Seconds are biased by a whole number of days so the dividend is unsigned.
  localparam int unsigned SecBiasDays = 24856;
  localparam logic [32:0] SecBias     = 33'd2147558400;

  // Day split: u / 86400 = (u >> 7) / 675, reciprocal of 675 at 2^36.
  localparam int          DayLoBits   = 7;
  localparam logic [26:0] Recip675    = 27'd101806633;
  localparam int          Shift675    = 36;
  localparam logic [9:0]  Div675      = 10'd675;

  // Year split: day count biased so that it is never negative.
  localparam int          YearBias    = 69;
  localparam logic [15:0] YearDayBias = 16'd329;
  localparam logic [16:0] Recip365    = 17'd91930;
  localparam int          Shift365    = 25;
  localparam logic [8:0]  Div365      = 9'd365;

  // Division by 60 for seconds of day and for minutes of day.
  localparam logic [17:0] Recip60Sec  = 18'd139811;
  localparam int          Shift60Sec  = 23;
  localparam logic [11:0] Recip60Min  = 12'd2185;
  localparam int          Shift60Min  = 17;
  localparam logic [5:0]  Div60       = 6'd60;

  localparam int          Months      = 12;

  typedef logic [8:0] doy_t;
  typedef logic [3:0] month_t;

  localparam doy_t MonthStart [Months] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  function automatic month_t month_of(input doy_t doy);
    month_t m;
    m = '0;
    for (int i = 1; i < Months; i++) begin
      if (doy >= MonthStart[i]) begin
        m = month_t'(i);
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- design/sctc_day_split.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sctc_day_split
// Three stages: bias, reciprocal multiply, remainder. Gives day count and
// seconds of day.
// ----------------------------------------------------------------------------
module sctc_day_split
  import sctc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               valid,
  input  wire logic signed [31:0] total_seconds,
  output logic                    day_valid,
  output logic [16:0]             day_biased,
  output logic [16:0]             sec_of_day
);

  logic        s1_valid;
  logic [32:0] s1_u;

  logic        s2_valid;
  logic [52:0] s2_prod;
  logic [25:0] s2_hi;
  logic [6:0]  s2_lo;

  logic [16:0] s2_days;
  logic [26:0] s2_back;
  logic [25:0] s2_rem_full;

  assign s2_days     = s2_prod[52:Shift675];
  assign s2_back     = 27'(s2_days) * 27'(Div675);
  assign s2_rem_full = s2_hi - s2_back[25:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      day_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= valid;
      s2_valid  <= s1_valid;
      day_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_u       <= {total_seconds[31], total_seconds} + SecBias;
      s2_prod    <= 53'(s1_u[32:DayLoBits]) * 53'(Recip675);
      s2_hi      <= s1_u[32:DayLoBits];
      s2_lo      <= s1_u[DayLoBits-1:0];
      day_biased <= s2_days;
      sec_of_day <= {s2_rem_full[9:0], s2_lo};
    end
  end

endmodule
`default_nettype wire

// ----- design/sctc_date_split.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sctc_date_split
// Three stages: reciprocal multiplies, remainders, month lookup and hours.
// ----------------------------------------------------------------------------
module sctc_date_split
  import sctc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        day_valid,
  input  wire logic [16:0] day_biased,
  input  wire logic [16:0] sec_of_day,
  output logic             cal_valid,
  output logic signed [7:0] year_offset,
  output logic [3:0]       month_index,
  output logic [4:0]       day_of_month,
  output logic [4:0]       hour_of_day,
  output logic [5:0]       minute_of_hour,
  output logic [5:0]       second_of_minute
);

  logic        s4_valid;
  logic [15:0] s4_w;
  logic [32:0] s4_py;
  logic [16:0] s4_tod;
  logic [34:0] s4_pm;

  logic        s5_valid;
  logic [7:0]  s5_year;
  doy_t        s5_doy;
  logic [10:0] s5_mins;
  logic [5:0]  s5_sec;

  logic [15:0] w_next;
  logic [7:0]  s4_years_b;
  logic [16:0] s4_yback;
  logic [15:0] s4_doy_full;
  logic [10:0] s4_mins;
  logic [16:0] s4_mback;
  logic [16:0] s4_sec_full;

  logic [22:0] s5_hprod;
  logic [4:0]  s5_hour;
  logic [10:0] s5_hback;
  logic [10:0] s5_min_full;
  month_t      s5_month;
  doy_t        s5_day_full;

  // day_biased - SecBiasDays + 365 * YearBias
  assign w_next      = 16'(day_biased) + YearDayBias;
  assign s4_years_b  = s4_py[Shift365+7:Shift365];
  assign s4_yback    = 17'(s4_years_b) * 17'(Div365);
  assign s4_doy_full = s4_w - s4_yback[15:0];
  assign s4_mins     = s4_pm[Shift60Sec+10:Shift60Sec];
  assign s4_mback    = 17'(s4_mins) * 17'(Div60);
  assign s4_sec_full = s4_tod - s4_mback;

  assign s5_hprod    = 23'(s5_mins) * 23'(Recip60Min);
  assign s5_hour     = s5_hprod[Shift60Min+4:Shift60Min];
  assign s5_hback    = 11'(s5_hour) * 11'(Div60);
  assign s5_min_full = s5_mins - s5_hback;
  assign s5_month    = month_of(s5_doy);
  assign s5_day_full = s5_doy - MonthStart[s5_month] + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      cal_valid <= 1'b0;
    end else if (en) begin
      s4_valid  <= day_valid;
      s5_valid  <= s4_valid;
      cal_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_w             <= w_next;
      s4_py            <= 33'(w_next) * 33'(Recip365);
      s4_tod           <= sec_of_day;
      s4_pm            <= 35'(sec_of_day) * 35'(Recip60Sec);
      s5_year          <= s4_years_b - 8'(YearBias);
      s5_doy           <= s4_doy_full[8:0];
      s5_mins          <= s4_mins;
      s5_sec           <= s4_sec_full[5:0];
      year_offset      <= s5_year;
      month_index      <= s5_month;
      day_of_month     <= s5_day_full[4:0];
      hour_of_day      <= s5_hour;
      minute_of_hour   <= s5_min_full[5:0];
      second_of_minute <= s5_sec;
    end
  end

endmodule
`default_nettype wire

// ----- design/seconds_to_calendar_fields.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_fields
// Splits signed seconds since the base date into calendar fields on a
// 365-day calendar.
//
// channel  handshake              payload
// sec      sec_valid/sec_ready    total_seconds
// cal      cal_valid/cal_ready    year_offset .. second_of_minute
//
// One request per cycle while cal is not stalled.
// The path runs through six register stages; each stage takes a new request
// every cycle that cal is not stalled.
// Reset clears the stage valid bits only.
// A stall on cal freezes every stage together; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module seconds_to_calendar_fields
  import sctc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sec_valid,
  output logic                    sec_ready,
  input  wire logic signed [31:0] total_seconds,
  output logic                    cal_valid,
  input  wire logic               cal_ready,
  output logic signed [7:0]       year_offset,
  output logic [3:0]              month_index,
  output logic [4:0]              day_of_month,
  output logic [4:0]              hour_of_day,
  output logic [5:0]              minute_of_hour,
  output logic [5:0]              second_of_minute
);

  logic        advance;
  logic        day_valid;
  logic [16:0] day_biased;
  logic [16:0] sec_of_day;

  assign advance   = !cal_valid || cal_ready;
  assign sec_ready = advance;

  sctc_day_split u_day (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .valid         (sec_valid),
    .total_seconds (total_seconds),
    .day_valid     (day_valid),
    .day_biased    (day_biased),
    .sec_of_day    (sec_of_day)
  );

  sctc_date_split u_date (
    .clk              (clk),
    .rst              (rst),
    .en               (advance),
    .day_valid        (day_valid),
    .day_biased       (day_biased),
    .sec_of_day       (sec_of_day),
    .cal_valid        (cal_valid),
    .year_offset      (year_offset),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

endmodule
`default_nettype wire

// ----- sim/seconds_to_calendar_fields_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_fields_test
// Self-checking bench for the seconds to calendar splitter. A table of
// directed requests covers zero, both ends of the 32-bit range, day, month
// and year edges either side of zero; random requests follow. Every result is
// compared field by field against the table's fields or an in-bench calendar
// model, with random idling on both channels and one long stall on the result side.
// ----------------------------------------------------------------------------
module seconds_to_calendar_fields_test;

  localparam int HoldCycles  = 300;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems  = 510;
  localparam int SecsPerDay  = 86400;
  localparam int DaysPerYear = 365;

  localparam int MonthFirstDay [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  typedef struct packed {
    logic signed [7:0] year_offset;
    logic [3:0]        month_index;
    logic [4:0]        day_of_month;
    logic [4:0]        hour_of_day;
    logic [5:0]        minute_of_hour;
    logic [5:0]        second_of_minute;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] secs;
    logic               typed;
    cal_t               want;
  } stim_row_t;

  localparam int DirectedCount = 25;

  // typed = 1: expected fields given here; otherwise taken from the model
  localparam stim_row_t DirectedRows [DirectedCount] = '{
    '{32'sd0,            1'b1, '{8'sd0,   4'd0,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{-32'sd1,           1'b1, '{-8'sd1,  4'd11, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{32'sd2147483647,   1'b1, '{8'sd68,  4'd1,  5'd5,  5'd3,  6'd14, 6'd7}},
    '{32'sh80000000,     1'b1, '{-8'sd69, 4'd10, 5'd26, 5'd20, 6'd45, 6'd52}},
    '{32'sd86399,        1'b1, '{8'sd0,   4'd0,  5'd1,  5'd23, 6'd59, 6'd59}},
    '{32'sd86400,        1'b1, '{8'sd0,   4'd0,  5'd2,  5'd0,  6'd0,  6'd0}},
    '{-32'sd86400,       1'b1, '{-8'sd1,  4'd11, 5'd31, 5'd0,  6'd0,  6'd0}},
    '{-32'sd86401,       1'b1, '{-8'sd1,  4'd11, 5'd30, 5'd23, 6'd59, 6'd59}},
    '{32'sd31535999,     1'b1, '{8'sd0,   4'd11, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{32'sd31536000,     1'b1, '{8'sd1,   4'd0,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{-32'sd31536000,    1'b1, '{-8'sd1,  4'd0,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{-32'sd31536001,    1'b0, '0},
    '{32'sd2678400,      1'b1, '{8'sd0,   4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'sd2678399,      1'b0, '0},
    '{32'sd5097600,      1'b1, '{8'sd0,   4'd2,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'sd28857600,     1'b1, '{8'sd0,   4'd11, 5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'sd3600,         1'b1, '{8'sd0,   4'd0,  5'd1,  5'd1,  6'd0,  6'd0}},
    '{32'sd59,           1'b1, '{8'sd0,   4'd0,  5'd1,  5'd0,  6'd0,  6'd59}},
    '{32'sd60,           1'b1, '{8'sd0,   4'd0,  5'd1,  5'd0,  6'd1,  6'd0}},
    '{32'sd12345678,     1'b0, '0},
    '{-32'sd12345678,    1'b0, '0},
    '{32'sh55555555,     1'b0, '0},
    '{32'shAAAAAAAA,     1'b0, '0},
    '{-32'sd2147483647,  1'b0, '0},
    '{32'sd2147472000,   1'b0, '0}
  };

  logic               clk;
  logic               rst;
  logic               sec_valid;
  logic               sec_ready;
  logic signed [31:0] total_seconds;
  logic               cal_valid;
  logic               cal_ready;
  logic signed [7:0]  year_offset;
  logic [3:0]         month_index;
  logic [4:0]         day_of_month;
  logic [4:0]         hour_of_day;
  logic [5:0]         minute_of_hour;
  logic [5:0]         second_of_minute;

  cal_t calendar_expected [$];
  int   errors = 0;
  int   quiet_cycles = 0;
  int   tx_idle_pct = 13;
  int   rx_idle_pct = 66;
  bit   hold_pending = 1'b0;

  seconds_to_calendar_fields DUT (
    .clk              (clk),
    .rst              (rst),
    .sec_valid        (sec_valid),
    .sec_ready        (sec_ready),
    .total_seconds    (total_seconds),
    .cal_valid        (cal_valid),
    .cal_ready        (cal_ready),
    .year_offset      (year_offset),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // floor division throughout, so time of day and day of year never go negative
  function automatic cal_t calendar_of(input logic signed [31:0] secs);
    longint s;
    longint days;
    longint tod;
    longint years;
    longint doy;
    int     m;
    cal_t   c;
    s = secs;
    days = s / SecsPerDay;
    tod = s % SecsPerDay;
    if (tod < 0) begin
      tod += SecsPerDay;
      days -= 1;
    end
    years = days / DaysPerYear;
    doy = days % DaysPerYear;
    if (doy < 0) begin
      doy += DaysPerYear;
      years -= 1;
    end
    m = 11;
    while (m > 0 && doy < MonthFirstDay[m]) m--;
    c.year_offset      = 8'(years);
    c.month_index      = 4'(m);
    c.day_of_month     = 5'(doy - MonthFirstDay[m] + 1);
    c.hour_of_day      = 5'(tod / 3600);
    c.minute_of_hour   = 6'((tod % 3600) / 60);
    c.second_of_minute = 6'(tod % 60);
    return c;
  endfunction

  function automatic logic signed [31:0] random_seconds();
    int unsigned pick;
    longint      v;
    pick = $urandom_range(99);
    if (pick < 50) begin
      v = longint'(int'($urandom));
    end else if (pick < 70) begin
      // within three years of the base date
      v = longint'($urandom_range(189216000)) - 94608000;
    end else if (pick < 90) begin
      // around a month start
      v = longint'(int'($urandom_range(135)) - 68) * DaysPerYear
          + MonthFirstDay[$urandom_range(11)];
      v = v * SecsPerDay + longint'($urandom_range(4)) - 2;
    end else if ($urandom_range(1)) begin
      v = 64'sd2147483647 - longint'($urandom_range(200000));
    end else begin
      v = -64'sd2147483648 + longint'($urandom_range(200000));
    end
    return 32'(v);
  endfunction

  task automatic flag(input string msg);
    $display("%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic offer(input logic signed [31:0] value, input logic typed, input cal_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      sec_valid <= 1'b0;
      @(negedge clk);
    end
    sec_valid     <= 1'b1;
    total_seconds <= value;
    do @(posedge clk); while (!sec_ready);
    calendar_expected.push_back(typed ? want : calendar_of(value));
    @(negedge clk);
  endtask

  // result side: random idling, plus one long hold when asked for
  initial begin
    cal_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        cal_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_pending = 1'b0;
      end
      cal_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cal_t want;
    if (!rst && cal_valid && cal_ready) begin
      if (calendar_expected.size() == 0) begin
        flag($sformatf("result with nothing outstanding: %0d-%0d-%0d %0d:%0d:%0d",
                       year_offset, month_index, day_of_month,
                       hour_of_day, minute_of_hour, second_of_minute));
      end else begin
        want = calendar_expected.pop_front();
        if (year_offset !== want.year_offset)
          flag($sformatf("year_offset: want %0d got %0d", want.year_offset, year_offset));
        if (month_index !== want.month_index)
          flag($sformatf("month_index: want %0d got %0d", want.month_index, month_index));
        if (day_of_month !== want.day_of_month)
          flag($sformatf("day_of_month: want %0d got %0d", want.day_of_month, day_of_month));
        if (hour_of_day !== want.hour_of_day)
          flag($sformatf("hour_of_day: want %0d got %0d", want.hour_of_day, hour_of_day));
        if (minute_of_hour !== want.minute_of_hour)
          flag($sformatf("minute_of_hour: want %0d got %0d",
                         want.minute_of_hour, minute_of_hour));
        if (second_of_minute !== want.second_of_minute)
          flag($sformatf("second_of_minute: want %0d got %0d",
                         want.second_of_minute, second_of_minute));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sec_valid && sec_ready) || (cal_valid && cal_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    sec_valid     = 1'b0;
    total_seconds = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DirectedCount; i++) begin
      offer(DirectedRows[i].secs, DirectedRows[i].typed, DirectedRows[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 66;
        end
        1: begin
          tx_idle_pct = 66;
          rx_idle_pct = 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_pending = 1'b1;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        offer(random_seconds(), 1'b0, '0);
      end
    end
    sec_valid <= 1'b0;

    while (calendar_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
